@@ hw/rtl/sil_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types and constants of the sectioned image loader.
// ----------------------------------------------------------------------------
package sil_pkg;

	localparam int unsigned CFG_INDEX_W = 1;

	localparam logic [31:0] MAGIC_WORD      = 32'hCAFE_F00D;
	localparam logic [15:0] TYPE_CODE       = 16'hC0DE;
	localparam logic [15:0] TYPE_DATA       = 16'hDADA;
	localparam logic [15:0] TYPE_SKIP_ADDR  = 16'hC3B7;
	localparam logic [15:0] TYPE_SKIP_COUNT = 16'hF17E;
	localparam logic [15:0] TYPE_FIXED      = 16'h715E;
	localparam logic [31:0] FIXED_SKIP_BYTES = 32'd12;

	localparam logic [31:0] PROGRAM_BASE_RST = 32'h1000_0000;
	localparam logic [31:0] DATA_BASE_RST    = 32'h2000_0000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PROGRAM_BASE = 1'b0,
		REG_DATA_BASE    = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_MAGIC = 3'd0,
		PH_TYPE  = 3'd1,
		PH_ADDR  = 3'd2,
		PH_COUNT = 3'd3,
		PH_CODE  = 3'd4,
		PH_DATA  = 3'd5,
		PH_SKIP  = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		KIND_NONE       = 3'd0,
		KIND_CODE       = 3'd1,
		KIND_DATA       = 3'd2,
		KIND_SKIP_ADDR  = 3'd3,
		KIND_SKIP_COUNT = 3'd4,
		KIND_FIXED      = 3'd5
	} sect_kind_t;

	typedef enum logic [1:0] {
		RES_PROGRAM_WRITE = 2'd0,
		RES_DATA_WRITE    = 2'd1,
		RES_LOAD_OK       = 2'd2,
		RES_LOAD_FAIL     = 2'd3
	} res_kind_t;

	typedef enum logic [1:0] {
		CAUSE_NONE     = 2'd0,
		CAUSE_MAGIC    = 2'd1,
		CAUSE_BAD_TYPE = 2'd2
	} cause_t;

	typedef struct packed {
		res_kind_t   kind;
		logic [31:0] index;
		logic [31:0] value;
		cause_t      cause;
	} result_t;

endpackage : sil_pkg
`default_nettype wire

@@ hw/rtl/sil_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sil_parser
// Parse state of the image file; consumes one beat per step and forms
// at most one result for it.
// ----------------------------------------------------------------------------
module sil_parser
	import sil_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        operation,
	input  wire logic [7:0]  file_byte,
	input  wire logic [31:0] program_base,
	input  wire logic [31:0] data_base,
	output logic             res_valid,
	output result_t          res
);

	phase_t      phase_q, phase_d;
	sect_kind_t  kind_q, kind_d;
	logic [1:0]  bpos_q, bpos_d;
	logic [31:0] shift_q, shift_d;
	logic [31:0] addr_q, addr_d;
	logic [31:0] count_q, count_d;
	logic [31:0] pidx_q, pidx_d;
	logic        failed_q, failed_d;

	logic [31:0] shifted;
	logic [31:0] pidx_inc;
	logic [31:0] code_off;
	logic        idx_done;
	logic        last4;
	logic        last2;

	assign shifted  = {shift_q[23:0], file_byte};
	assign pidx_inc = pidx_q + 32'd1;
	assign idx_done = (pidx_inc == count_q);
	assign last4    = (bpos_q == 2'd3);
	assign last2    = bpos_q[0];
	assign code_off = addr_q - program_base;

	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		bpos_d    = bpos_q;
		shift_d   = shift_q;
		addr_d    = addr_q;
		count_d   = count_q;
		pidx_d    = pidx_q;
		failed_d  = failed_q;
		res_valid = 1'b0;
		res       = '0;

		if (operation) begin
			phase_d  = PH_MAGIC;
			kind_d   = KIND_NONE;
			bpos_d   = '0;
			shift_d  = '0;
			addr_d   = '0;
			count_d  = '0;
			pidx_d   = '0;
			failed_d = 1'b0;
			if (!failed_q) begin
				res_valid = 1'b1;
				res.kind  = RES_LOAD_OK;
			end
		end else if (!failed_q) begin
			case (phase_q)
				PH_MAGIC: begin
					if (last4) begin
						bpos_d = '0;
						if (shifted != MAGIC_WORD) begin
							shift_d   = shifted;
							failed_d  = 1'b1;
							res_valid = 1'b1;
							res.kind  = RES_LOAD_FAIL;
							res.cause = CAUSE_MAGIC;
						end else begin
							phase_d = PH_TYPE;
							shift_d = '0;
						end
					end else begin
						shift_d = shifted;
						bpos_d  = bpos_q + 2'd1;
					end
				end
				PH_TYPE: begin
					if (last2) begin
						bpos_d  = '0;
						shift_d = '0;
						pidx_d  = '0;
						case (shifted[15:0])
							TYPE_CODE: begin
								kind_d  = KIND_CODE;
								phase_d = PH_ADDR;
							end
							TYPE_DATA: begin
								kind_d  = KIND_DATA;
								phase_d = PH_ADDR;
							end
							TYPE_SKIP_ADDR: begin
								kind_d  = KIND_SKIP_ADDR;
								phase_d = PH_ADDR;
							end
							TYPE_SKIP_COUNT: begin
								kind_d  = KIND_SKIP_COUNT;
								phase_d = PH_COUNT;
							end
							TYPE_FIXED: begin
								kind_d  = KIND_FIXED;
								count_d = FIXED_SKIP_BYTES;
								phase_d = PH_SKIP;
							end
							default: begin
								failed_d  = 1'b1;
								res_valid = 1'b1;
								res.kind  = RES_LOAD_FAIL;
								res.cause = CAUSE_BAD_TYPE;
							end
						endcase
					end else begin
						shift_d = shifted;
						bpos_d  = bpos_q + 2'd1;
					end
				end
				PH_ADDR: begin
					if (last4) begin
						bpos_d  = '0;
						shift_d = '0;
						addr_d  = shifted;
						phase_d = PH_COUNT;
					end else begin
						shift_d = shifted;
						bpos_d  = bpos_q + 2'd1;
					end
				end
				PH_COUNT: begin
					if (last4) begin
						bpos_d  = '0;
						shift_d = '0;
						count_d = shifted;
						pidx_d  = '0;
						if (shifted == 32'd0) begin
							phase_d = PH_TYPE;
						end else if (kind_q == KIND_CODE) begin
							phase_d = PH_CODE;
						end else if (kind_q == KIND_DATA) begin
							phase_d = PH_DATA;
						end else begin
							phase_d = PH_SKIP;
						end
					end else begin
						shift_d = shifted;
						bpos_d  = bpos_q + 2'd1;
					end
				end
				PH_CODE: begin
					if (last4) begin
						bpos_d    = '0;
						shift_d   = '0;
						pidx_d    = pidx_inc;
						res_valid = 1'b1;
						res.kind  = RES_PROGRAM_WRITE;
						res.index = {2'b00, code_off[31:2]} + pidx_q;
						res.value = shifted;
						if (idx_done) begin
							phase_d = PH_TYPE;
						end
					end else begin
						shift_d = shifted;
						bpos_d  = bpos_q + 2'd1;
					end
				end
				PH_DATA: begin
					pidx_d    = pidx_inc;
					res_valid = 1'b1;
					res.kind  = RES_DATA_WRITE;
					res.index = addr_q - data_base + pidx_q;
					res.value = {24'd0, file_byte};
					if (idx_done) begin
						phase_d = PH_TYPE;
						shift_d = '0;
						bpos_d  = '0;
					end
				end
				PH_SKIP: begin
					pidx_d = pidx_inc;
					if (idx_done) begin
						phase_d = PH_TYPE;
						shift_d = '0;
						bpos_d  = '0;
					end
				end
				default: begin
					phase_d = PH_MAGIC;
					kind_d  = KIND_NONE;
					bpos_d  = '0;
					shift_d = '0;
					addr_d  = '0;
					count_d = '0;
					pidx_d  = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC;
			kind_q   <= KIND_NONE;
			bpos_q   <= '0;
			shift_q  <= '0;
			addr_q   <= '0;
			count_q  <= '0;
			pidx_q   <= '0;
			failed_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			kind_q   <= kind_d;
			bpos_q   <= bpos_d;
			shift_q  <= shift_d;
			addr_q   <= addr_d;
			count_q  <= count_d;
			pidx_q   <= pidx_d;
			failed_q <= failed_d;
		end
	end

endmodule : sil_parser
`default_nettype wire

@@ hw/rtl/sil_result_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sil_result_reg
// Output register of the result channel; holds a beat while stalled.
// ----------------------------------------------------------------------------
module sil_result_reg
	import sil_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res_in,
	input  wire logic    stall,
	output logic         ready,
	output logic         valid,
	output result_t      res_out
);

	logic    valid_q;
	result_t res_q;

	assign ready   = !valid_q || !stall;
	assign valid   = valid_q;
	assign res_out = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			res_q <= res_in;
		end
	end

endmodule : sil_result_reg
`default_nettype wire

@@ hw/rtl/sectioned_image_loader.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sectioned_image_loader
// Parses an image file byte by byte into program and data memory writes.
//
// Input channel (item_valid / item_stall): one beat per file byte, or an
// end-of-file beat with operation high. Result channel (result_valid /
// result_stall): program word writes, data byte writes and a final status
// beat. Config channel (cfg_valid / cfg_ready, always ready) sets
// program_base and data_base; write it only while the block is idle.
// Throughput is one input beat per cycle unless the result port stalls,
// set by the single parse step between the input and output registers. A
// beat and its result pass the input and then the output register. While
// result_stall is high and a result is held, item_stall rises as soon as
// the input register is full, so at most two beats are in flight. Reset
// clears the parse state, restores the default bases and empties both
// registers; the block is then waiting for the magic word.
// ----------------------------------------------------------------------------
module sectioned_image_loader
	import sil_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire logic                   operation,
	input  wire logic [7:0]             file_byte,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic [1:0]                  result_kind,
	output logic [31:0]                 write_index,
	output logic [31:0]                 write_value,
	output logic [1:0]                  failure_cause,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]            cfg_data
);

	logic [31:0] program_base_q;
	logic [31:0] data_base_q;

	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;

	logic        out_ready;
	logic        step;
	logic        accept;
	logic        res_valid;
	result_t     res;
	result_t     res_out;

	assign cfg_ready  = 1'b1;
	assign step       = valid_s1 && out_ready;
	assign item_stall = valid_s1 && !out_ready;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_base_q <= PROGRAM_BASE_RST;
			data_base_q    <= DATA_BASE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PROGRAM_BASE: program_base_q <= cfg_data;
				REG_DATA_BASE:    data_base_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	// input register: refill in the same cycle the held beat is parsed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			byte_s1 <= file_byte;
		end
	end

	sil_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.operation    (op_s1),
		.file_byte    (byte_s1),
		.program_base (program_base_q),
		.data_base    (data_base_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	sil_result_reg u_result (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step && res_valid),
		.res_in  (res),
		.stall   (result_stall),
		.ready   (out_ready),
		.valid   (result_valid),
		.res_out (res_out)
	);

	assign result_kind   = res_out.kind;
	assign write_index   = res_out.index;
	assign write_value   = res_out.value;
	assign failure_cause = res_out.cause;

endmodule : sectioned_image_loader
`default_nettype wire
